FILE: src/cdsb_pkg.sv
// Shared types and constants for the sparse diagonal-scaling gradient block.
// No dependencies.
package cdsb_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned ACC_W = 48;
    localparam int unsigned OP_W = 32;

    // input item kinds
    localparam logic [KIND_W-1:0] K_LOAD_L = 3'd0;
    localparam logic [KIND_W-1:0] K_LOAD_R = 3'd1;
    localparam logic [KIND_W-1:0] K_ENTRY = 3'd2;
    localparam logic [KIND_W-1:0] K_READ_ROW = 3'd3;
    localparam logic [KIND_W-1:0] K_READ_COL = 3'd4;

    // result kinds
    localparam logic [1:0] RK_ENTRY = 2'd0;
    localparam logic [1:0] RK_ROW = 2'd1;
    localparam logic [1:0] RK_COL = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch input item
        logic clr_we;    // clearing-pass write of both accumulators
        logic mul1;      // register first-stage products
        logic mul2;      // register second-stage products
        logic wb;        // write scale and accumulator memories back
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

    // floor Q16.16 product of two 32-bit operands, as 48-bit slice >> 16
    function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

FILE: src/cdsb_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module cdsb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/cdsb_ctrl.sv
// Controller: clearing pass, per-item sequence and output handshake.
// Depends on cdsb_pkg.
module cdsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_has_result,
    output cdsb_pkg::t_cmd    o_cmd,
    input  cdsb_pkg::t_sts    i_sts
);
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_M1    = 6'b001000,
        S_M2    = 6'b010000,
        S_WB    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_acc;
    logic   w_out_busy;

    assign w_acc = i_in_valid && o_in_ready;
    // items are taken in idle; the output register drains in parallel
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_busy = r_out_valid && !i_out_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_out_valid = w_out_busy;
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.capture = w_acc;
                if (w_acc) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                // a result waits here while the previous one is still held
                if (!(i_has_result && w_out_busy)) begin
                    o_cmd.wb = 1'b1;
                    o_cmd.out_load = i_has_result;
                    if (i_has_result) n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state == S_RD) else $error("accepted item not started");
    a_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb |=> r_state == S_IDLE) else $error("writeback not final");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !w_out_busy) else $error("held result overwritten");
endmodule

FILE: src/cdsb_dp.sv
// Datapath: scale and accumulator memories, two product stages, saturation.
// Depends on cdsb_pkg and cdsb_ram.
module cdsb_dp #(
    parameter int unsigned MAX_ROWS = 1024,
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdsb_pkg::t_cmd       i_cmd,
    output cdsb_pkg::t_sts       o_sts,
    input  logic [2:0]           i_kind,
    input  logic [9:0]           i_index,
    input  logic signed [31:0]   i_scale,
    input  logic [9:0]           i_row,
    input  logic [9:0]           i_col,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_grad,
    output logic                 o_has_result,
    output logic [1:0]           o_result_kind,
    output logic [9:0]           o_result_index,
    output logic signed [47:0]   o_result_value
);
    localparam int unsigned RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned CLR_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int unsigned CLW = $clog2(CLR_N + 1);
    localparam logic signed [47:0] VMAX = (48'sd1 <<< (VALUE_WIDTH - 1)) - 48'sd1;
    localparam logic signed [47:0] VMIN = -VMAX - 48'sd1;

    // captured item
    logic [2:0] r_kind;
    logic [9:0] r_index, r_row, r_col;
    logic signed [31:0] r_scale, r_value, r_grad;
    logic r_row_ok, r_col_ok, r_idx_r_ok, r_idx_c_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_index <= i_index;
            r_scale <= i_scale;
            r_row <= i_row;
            r_col <= i_col;
            r_value <= i_value;
            r_grad <= i_grad;
            r_row_ok <= 32'(i_row) < MAX_ROWS;
            r_col_ok <= 32'(i_col) < MAX_COLS;
            r_idx_r_ok <= 32'(i_index) < MAX_ROWS;
            r_idx_c_ok <= 32'(i_index) < MAX_COLS;
        end
    end

    // clearing pass counter
    logic [CLW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_we) r_clr <= r_clr + CLW'(1);
    end
    assign o_sts.clr_done = (r_clr == CLW'(CLR_N - 1));

    // addresses: row/col side for entries, index for reads
    logic w_is_entry;
    logic [RA-1:0] w_raddr;
    logic [CA-1:0] w_caddr;
    assign w_is_entry = (r_kind == cdsb_pkg::K_ENTRY);
    assign w_raddr = w_is_entry ? RA'(r_row) : RA'(r_index);
    assign w_caddr = w_is_entry ? CA'(r_col) : CA'(r_index);

    logic [31:0] w_l, w_r;
    logic [47:0] w_racc, w_cacc;
    logic        w_rwe, w_cwe;
    logic [47:0] w_rwd, w_cwd;
    logic [RA-1:0] w_rwa;
    logic [CA-1:0] w_cwa;

    cdsb_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_left (
        .i_clk(i_clk),
        .i_we(i_cmd.wb && r_kind == cdsb_pkg::K_LOAD_L && r_idx_r_ok),
        .i_waddr(RA'(r_index)), .i_wdata(r_scale),
        .i_raddr(w_raddr), .o_rdata(w_l));
    cdsb_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_right (
        .i_clk(i_clk),
        .i_we(i_cmd.wb && r_kind == cdsb_pkg::K_LOAD_R && r_idx_c_ok),
        .i_waddr(CA'(r_index)), .i_wdata(r_scale),
        .i_raddr(w_caddr), .o_rdata(w_r));
    cdsb_ram #(.WIDTH(48), .DEPTH(MAX_ROWS)) u_rowacc (
        .i_clk(i_clk), .i_we(w_rwe), .i_waddr(w_rwa), .i_wdata(w_rwd),
        .i_raddr(w_raddr), .o_rdata(w_racc));
    cdsb_ram #(.WIDTH(48), .DEPTH(MAX_COLS)) u_colacc (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(w_cwa), .i_wdata(w_cwd),
        .i_raddr(w_caddr), .o_rdata(w_cacc));

    // stage 1: grad*value and grad*left; hold scales and accumulators
    logic signed [31:0] r_t, r_gl, r_l, r_r;
    logic signed [47:0] r_racc, r_cacc;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_t <= cdsb_pkg::sat32(cdsb_pkg::qmul(r_grad, r_value));
            r_gl <= cdsb_pkg::sat32(cdsb_pkg::qmul(r_grad, w_l));
            r_l <= w_l;
            r_r <= w_r;
            r_racc <= w_racc;
            r_cacc <= w_cacc;
        end
    end

    // stage 2: the three second products
    logic signed [47:0] r_res, r_rc, r_cc;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_res <= cdsb_pkg::qmul(r_gl, r_r);
            r_rc <= cdsb_pkg::qmul(r_t, r_r);
            r_cc <= cdsb_pkg::qmul(r_t, r_l);
        end
    end

    // saturating 48-bit accumulate
    function automatic logic [47:0] sat_add(input logic signed [47:0] a,
                                            input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        return s[47:0];
    endfunction

    logic w_ent_ok;
    assign w_ent_ok = w_is_entry && r_row_ok && r_col_ok;

    // accumulator writes: clearing pass, entry update, read-and-clear
    always_comb begin
        w_rwe = 1'b0;
        w_cwe = 1'b0;
        w_rwa = w_raddr;
        w_cwa = w_caddr;
        w_rwd = '0;
        w_cwd = '0;
        if (i_cmd.clr_we) begin
            w_rwe = 1'b1;
            w_cwe = 1'b1;
            w_rwa = RA'(r_clr);
            w_cwa = CA'(r_clr);
        end else if (i_cmd.wb) begin
            if (w_ent_ok) begin
                w_rwe = 1'b1;
                w_cwe = 1'b1;
                w_rwd = sat_add(r_racc, r_rc);
                w_cwd = sat_add(r_cacc, r_cc);
            end else if (r_kind == cdsb_pkg::K_READ_ROW && r_idx_r_ok) begin
                w_rwe = 1'b1;
            end else if (r_kind == cdsb_pkg::K_READ_COL && r_idx_c_ok) begin
                w_cwe = 1'b1;
            end
        end
    end

    assign o_has_result = w_is_entry || r_kind == cdsb_pkg::K_READ_ROW
                          || r_kind == cdsb_pkg::K_READ_COL;

    // output register
    logic signed [47:0] w_val;
    logic [1:0] w_rk;
    logic [9:0] w_ri;
    always_comb begin
        w_val = '0;
        w_rk = cdsb_pkg::RK_ENTRY;
        w_ri = r_row;
        if (w_is_entry) begin
            if (w_ent_ok) w_val = (r_res > VMAX) ? VMAX : (r_res < VMIN) ? VMIN : r_res;
        end else if (r_kind == cdsb_pkg::K_READ_ROW) begin
            w_rk = cdsb_pkg::RK_ROW;
            w_ri = r_index;
            if (r_idx_r_ok) w_val = r_racc;
        end else begin
            w_rk = cdsb_pkg::RK_COL;
            w_ri = r_index;
            if (r_idx_c_ok) w_val = r_cacc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_kind <= w_rk;
            o_result_index <= w_ri;
            o_result_value <= w_val;
        end
    end

    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_we |-> !i_cmd.wb && !i_cmd.capture) else $error("clear overlaps item");
    a_load_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_has_result) else $error("result from silent item");
    a_wb_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> !i_cmd.mul1 && !i_cmd.mul2) else $error("writeback overlaps products");
endmodule

FILE: src/csr_diag_scale_backprop_core.sv
// Top level of the sparse diagonal-scaling gradient block.
// Depends on cdsb_pkg, cdsb_ctrl, cdsb_dp, cdsb_ram.
//
// channel | dir | tdata fields (low bit up)                               | tuser
// s_axis  | in  | index[9:0] scale[41:10] row[51:42] col[61:52]           | kind[2:0]
//         |     | value[93:62] grad[125:94], zero to 128 bits             |
// m_axis  | out | index[9:0] value[57:10], zero to 64 bits                | result_kind[1:0]
//
// Each item goes through capture, memory read, two product stages and writeback;
// a new item is taken only after writeback. After reset a clearing pass zeroes
// all max(MAX_ROWS, MAX_COLS) accumulator addresses; no item is taken meanwhile.
// A stalled result holds the next result-producing item in writeback until the
// stalled result is transferred.
module csr_diag_scale_backprop_core #(
    parameter int unsigned MAX_ROWS = 1024,
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // index, scale_value, entry_row, entry_col,
                                        // entry_value, entry_grad
    input  logic [2:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // result_index, result_value
    output logic [1:0]   m_axis_tuser   // result_kind
);
    cdsb_pkg::t_cmd w_cmd;
    cdsb_pkg::t_sts w_sts;
    logic w_has;
    logic [9:0] w_ri;
    logic signed [47:0] w_rv;

    cdsb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_has_result(w_has), .o_cmd(w_cmd), .i_sts(w_sts));

    cdsb_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind(s_axis_tuser), .i_index(s_axis_tdata[9:0]),
        .i_scale(s_axis_tdata[41:10]), .i_row(s_axis_tdata[51:42]),
        .i_col(s_axis_tdata[61:52]), .i_value(s_axis_tdata[93:62]),
        .i_grad(s_axis_tdata[125:94]),
        .o_has_result(w_has), .o_result_kind(m_axis_tuser),
        .o_result_index(w_ri), .o_result_value(w_rv));

    assign m_axis_tdata = {6'd0, w_rv, w_ri};
endmodule

FILE: tb/csr_diag_scale_backprop_core_tb.sv
// Self-checking testbench for csr_diag_scale_backprop_core: directed table, then random
// streams of loads, sparse entries and gradient reads, checked against an internal predictor.
// Depends on cdsb_pkg and the core RTL.
module csr_diag_scale_backprop_core_tb;

    localparam int NROWS = 1024;
    localparam int NCOLS = 1024;
    localparam int NPRE = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] K_BAD = 3'd7;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         index;
        logic signed [31:0] scale;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] grad;
    } t_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         index;
        logic signed [47:0] value;
    } t_grad;

    // directed row: item plus optional typed-in expectation
    typedef struct packed {
        t_item              it;
        logic               has_exp;
        logic signed [47:0] exp_value;
    } t_drow;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    csr_diag_scale_backprop_core dut (.*);

    // predictor state
    logic signed [31:0] left_sc[NROWS];
    logic signed [31:0] right_sc[NCOLS];
    logic signed [47:0] row_acc[NROWS];
    logic signed [47:0] col_acc[NCOLS];
    bit left_set[NROWS];
    bit right_set[NCOLS];

    t_grad pending_grads[$];
    int    fail_count;
    int    result_count;
    int    entry_count;
    int    read_count;
    int    cycle_count;
    int    sender_idle_pct;
    int    receiver_stall_pct;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // floor Q16.16 product
    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [63:0] v, int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // apply one item to the predictor; returns 1 with the gradient result if one is due
    function automatic bit backprop_step(input t_item it, output t_grad g);
        logic signed [63:0] t, gl, l, r;
        g = '0;
        case (it.kind)
            cdsb_pkg::K_LOAD_L: begin
                left_sc[it.index] = it.scale;
                left_set[it.index] = 1'b1;
                return 1'b0;
            end
            cdsb_pkg::K_LOAD_R: begin
                right_sc[it.index] = it.scale;
                right_set[it.index] = 1'b1;
                return 1'b0;
            end
            cdsb_pkg::K_ENTRY: begin
                l = 64'(left_sc[it.row]);
                r = 64'(right_sc[it.col]);
                t = clamp(fx_mul(64'(it.grad), 64'(it.value)), 32);
                gl = clamp(fx_mul(64'(it.grad), l), 32);
                g.kind = cdsb_pkg::RK_ENTRY;
                g.index = it.row;
                g.value = 48'(clamp(fx_mul(gl, r), 32));
                row_acc[it.row] = 48'(clamp(row_acc[it.row] + fx_mul(t, r), 48));
                col_acc[it.col] = 48'(clamp(col_acc[it.col] + fx_mul(t, l), 48));
                return 1'b1;
            end
            cdsb_pkg::K_READ_ROW: begin
                g.kind = cdsb_pkg::RK_ROW;
                g.index = it.index;
                g.value = row_acc[it.index];
                row_acc[it.index] = '0;
                return 1'b1;
            end
            cdsb_pkg::K_READ_COL: begin
                g.kind = cdsb_pkg::RK_COL;
                g.index = it.index;
                g.value = col_acc[it.index];
                col_acc[it.index] = '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, result_count);
        fail_count++;
    endtask

    // send one item; waits for the transfer, tvalid stays up for the next item
    task automatic send_item(input t_item it);
        t_grad g;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.kind;
        s_axis_tdata <= {2'b0, it.grad, it.value, it.col, it.row, it.scale, it.index};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (backprop_step(it, g)) pending_grads.push_back(g);
        if (it.kind == cdsb_pkg::K_ENTRY) entry_count++;
        if (it.kind == cdsb_pkg::K_READ_ROW || it.kind == cdsb_pkg::K_READ_COL) read_count++;
    endtask

    // stop sending and wait for every expected result
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_grads.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall, check each transfer
    always @(posedge i_clk) begin
        t_grad want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (pending_grads.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    want = pending_grads.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("result_kind", 64'(m_axis_tuser), 64'(want.kind));
                    if (m_axis_tdata[9:0] !== want.index)
                        report_mismatch("result_index", 64'(m_axis_tdata[9:0]),
                                        64'(want.index));
                    if (m_axis_tdata[57:10] !== want.value)
                        report_mismatch("result_value", 64'(m_axis_tdata[57:10]),
                                        64'(want.value));
                end
            end
            m_axis_tready <= !(receiver_stall_pct > 0 &&
                               $urandom_range(99) < receiver_stall_pct);
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL csr_diag_scale_backprop_core");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_q;
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(131072)) - 32'sd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item(int nidx);
        t_item it;
        int sel;
        it = '0;
        it.index = 10'($urandom);
        it.scale = $urandom;
        it.row = 10'($urandom);
        it.col = 10'($urandom);
        it.value = rand_q();
        it.grad = rand_q();
        sel = $urandom_range(99);
        if (sel < 55) begin
            it.kind = cdsb_pkg::K_ENTRY;
            it.row = 10'($urandom_range(nidx - 1));
            it.col = 10'($urandom_range(nidx - 1));
        end else if (sel < 67) begin
            it.kind = cdsb_pkg::K_LOAD_L;
            it.index = 10'($urandom_range(nidx - 1));
            it.scale = rand_q();
        end else if (sel < 79) begin
            it.kind = cdsb_pkg::K_LOAD_R;
            it.index = 10'($urandom_range(nidx - 1));
            it.scale = rand_q();
        end else if (sel < 88) begin
            it.kind = cdsb_pkg::K_READ_ROW;
            if ($urandom_range(3) != 0) it.index = 10'($urandom_range(nidx - 1));
        end else if (sel < 97) begin
            it.kind = cdsb_pkg::K_READ_COL;
            if ($urandom_range(3) != 0) it.index = 10'($urandom_range(nidx - 1));
        end else begin
            it.kind = 3'($urandom_range(7, 5));
        end
        return it;
    endfunction

    // directed table
    t_drow dtab[$];

    function automatic t_item mk(logic [2:0] k, logic [9:0] idx, logic signed [31:0] sc,
                                 logic [9:0] r, logic [9:0] c, logic signed [31:0] v,
                                 logic signed [31:0] g);
        t_item it;
        it.kind = k; it.index = idx; it.scale = sc; it.row = r; it.col = c;
        it.value = v; it.grad = g;
        return it;
    endfunction

    initial begin
        t_grad g;
        t_item it;
        int phase;
        int n;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        fail_count = 0;
        result_count = 0;
        entry_count = 0;
        read_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int k = 0; k < NROWS; k++) begin
            left_sc[k] = '0; row_acc[k] = '0; left_set[k] = 0;
        end
        for (int k = 0; k < NCOLS; k++) begin
            right_sc[k] = '0; col_acc[k] = '0; right_set[k] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads after reset are zero, unknown kinds, extremes
        dtab.push_back({mk(cdsb_pkg::K_READ_ROW, 10'd0, 0, 0, 0, 0, 0), 1'b1, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_COL, 10'd1023, 0, 0, 0, 0, 0), 1'b1, 48'sd0});
        dtab.push_back({mk(K_BAD, 10'd5, 32'sh1234, 0, 0, 0, 0), 1'b0, 48'sd0});
        dtab.push_back({mk(3'd5, 0, 0, 0, 0, 0, 0), 1'b0, 48'sd0});
        dtab.push_back({mk(3'd6, 10'h3FF, -1, 10'h3FF, 10'h3FF, -1, -1), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_LOAD_L, 10'd0, 32'sh0001_0000, 0, 0, 0, 0),
                        1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_LOAD_R, 10'd0, 32'sh0001_0000, 0, 0, 0, 0),
                        1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_LOAD_L, 10'd1023, 32'sh7FFF_FFFF, 0, 0, 0, 0),
                        1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_LOAD_R, 10'd1023, 32'sh8000_0000, 0, 0, 0, 0),
                        1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd0, 10'd0, 32'sh0002_0000,
                           32'sh0003_0000), 1'b1, 48'sh3_0000});
        dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd1023, 10'd1023, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF), 1'b1, -48'sh8000_0000});
        dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd1023, 10'd1023, 32'sh8000_0000,
                           32'sh8000_0000), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd1023, 10'd0, -1, 32'sh8000_0000),
                        1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd0, 10'd1023, 32'sh8000_0000, -1),
                        1'b0, 48'sd0});
        // drive accumulator toward 48-bit saturation
        for (int k = 0; k < 4; k++)
            dtab.push_back({mk(cdsb_pkg::K_ENTRY, 0, 0, 10'd1023, 10'd1023, 32'sh8000_0000,
                               32'sh8000_0000), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_ROW, 10'd1023, 0, 0, 0, 0, 0), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_COL, 10'd1023, 0, 0, 0, 0, 0), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_ROW, 10'd1023, 0, 0, 0, 0, 0), 1'b1, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_ROW, 10'd0, 0, 0, 0, 0, 0), 1'b0, 48'sd0});
        dtab.push_back({mk(cdsb_pkg::K_READ_COL, 10'd0, 0, 0, 0, 0, 0), 1'b0, 48'sd0});

        foreach (dtab[k]) begin
            send_item(dtab[k].it);
            if (dtab[k].has_exp) begin
                g = pending_grads[$];
                if (g.value !== dtab[k].exp_value)
                    report_mismatch("directed table", 64'(g.value), 64'(dtab[k].exp_value));
            end
        end
        drain();

        // preload the scales of the random index pool so no entry reads an unwritten scale
        for (int k = 0; k < NPRE; k++) begin
            send_item(mk(cdsb_pkg::K_LOAD_L, k[9:0], rand_q(), 0, 0, 0, 0));
            send_item(mk(cdsb_pkg::K_LOAD_R, k[9:0], rand_q(), 0, 0, 0, 0));
        end
        drain();

        // random phases: idle/stall mixes, small index pools to collide accumulators
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            for (n = 0; n < 160; n++) begin
                it = rand_item(phase < 4 ? 8 : NPRE);
                send_item(it);
                if (n == 80 && phase == 2) drain();
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // flush all accumulators of the small pool
        for (int k = 0; k < 8; k++) begin
            send_item(mk(cdsb_pkg::K_READ_ROW, k[9:0], 0, 0, 0, 0, 0));
            send_item(mk(cdsb_pkg::K_READ_COL, k[9:0], 0, 0, 0, 0, 0));
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d sparse entries and %0d gradient reads, %0d results checked",
                 entry_count, read_count, result_count);
        $display("under mixed sender idling and receiver stalls");
        if (fail_count == 0 && pending_grads.size() == 0) begin
            $display("PASS csr_diag_scale_backprop_core");
        end else begin
            $display("FAIL csr_diag_scale_backprop_core");
        end
        $finish;
    end

endmodule
